// ===== rtl/hsl_to_rgb_integer_defines.svh =====
// ----------------------------------------------------------------------------
// HSL to RGB assertion macros
// Shared assertion forms, clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_INTEGER_DEFINES_SVH
`define HSL_TO_RGB_INTEGER_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define HSL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its cause
`define HSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hslrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSL to RGB package
// Widths, constants and the stage control type shared by the converter.
// ----------------------------------------------------------------------------
package hslrgb_pkg;

    // Field widths
    localparam int HUE_W    = 9;
    localparam int PCT_W    = 7;
    localparam int CHAN_W   = 8;

    // Internal widths: levels in hundredths of a percent, ramp weight, ramp
    localparam int LEVEL_W  = 14;
    localparam int WEIGHT_W = 6;
    localparam int RAMP_W   = 20;
    localparam int SCALED_W = 24;
    localparam int MUL_W    = 25;
    localparam int PROD_W   = SCALED_W + MUL_W;

    // Hue geometry in degrees
    localparam int HUE_WRAP     = 360;
    localparam int HUE_THIRD    = 120;
    localparam int HUE_TWO_THRD = 240;
    localparam int SEG_RISE_END = 60;
    localparam int SEG_FLAT_END = 180;
    localparam int SEG_FALL_END = 240;

    // Percent limits
    localparam int PCT_MAX  = 100;
    localparam int PCT_HALF = 50;
    localparam int LEVEL_SUM = 200;

    // Ramp scale: ramp * 255 / 600000 == ramp * 17 / 40000
    localparam int RAMP_MAX   = 600000;
    localparam int SCALE_NUM  = 17;
    // ceil(2^40 / 40000); exact floor for products below 2^26
    localparam logic [MUL_W-1:0] DIV_MUL = 25'd27487791;
    localparam int DIV_SHIFT = 40;

    // Per-stage load enables and valid flags for the channel stages
    typedef struct packed {
        logic ld4;
        logic ld5;
        logic ld6;
        logic vld3;
        logic vld4;
        logic vld5;
    } hslrgb_stage_t;

endpackage

// ===== rtl/hslrgb_chan.sv =====
// ----------------------------------------------------------------------------
// HSL to RGB channel back end
// Forms one channel's hue ramp from the two levels and scales it to 8 bits.
// ----------------------------------------------------------------------------
`include "hsl_to_rgb_integer_defines.svh"

module hslrgb_chan (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  hslrgb_pkg::hslrgb_stage_t           stage,
    input  logic [hslrgb_pkg::LEVEL_W-1:0]      lower,
    input  logic [hslrgb_pkg::LEVEL_W-1:0]      diff,
    input  logic [hslrgb_pkg::WEIGHT_W-1:0]     weight,
    output logic [hslrgb_pkg::CHAN_W-1:0]       level
);
    import hslrgb_pkg::*;

    logic [RAMP_W-1:0]   ramp_next, ramp_reg;
    logic [SCALED_W-1:0] scaled_next, scaled_reg;
    logic [PROD_W-1:0]   prod;
    logic [CHAN_W-1:0]   level_reg;

    // Ramp: lower*60 + (upper-lower)*weight, never above upper*60
    assign ramp_next = RAMP_W'(RAMP_W'(lower) * RAMP_W'(SEG_RISE_END))
                     + RAMP_W'(RAMP_W'(diff) * RAMP_W'(weight));

    // Times 17 by shift and add
    assign scaled_next = (SCALED_W'(ramp_reg) << 4) + SCALED_W'(ramp_reg);

    // Divide by 40000 through the reciprocal
    assign prod = PROD_W'(scaled_reg) * PROD_W'(DIV_MUL);

    always_ff @(posedge aclk) begin
        if (stage.ld4) begin
            ramp_reg <= ramp_next;
        end
        if (stage.ld5) begin
            scaled_reg <= scaled_next;
        end
        if (stage.ld6) begin
            level_reg <= prod[DIV_SHIFT +: CHAN_W];
        end
    end

    assign level = level_reg;

    `HSL_ASSERT_NEXT(a_ramp_bound, stage.ld4 && stage.vld3, ramp_reg <= RAMP_W'(RAMP_MAX), "ramp above full scale")
    `HSL_ASSERT_NOW(a_quot_fits, stage.ld6 && stage.vld5, prod[PROD_W-1:DIV_SHIFT+CHAN_W] == '0, "scaled channel exceeds 8 bits")

endmodule

// ===== rtl/hsl_to_rgb_integer.sv =====
// ----------------------------------------------------------------------------
// HSL to RGB pixel converter
// Integer HSL to 8-bit RGB conversion, one pixel per clock while m_tready is high.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one pixel per word: hue in degrees (hue above 359
//   wraps modulo 360), saturation and lightness in percent (clamped to 100).
//   m_ channel returns one word per pixel with red, green and blue.
//   A word is taken at a rising edge of aclk with tvalid and tready high.
//   Pipeline: a pixel passes six register stages on its way to m_, and the
//   last one of them is the output register.
//   Throughput: one pixel per cycle while m_tready stays high; the stage that
//   bounds it is the 24 x 25 reciprocal multiply in the last stage, fully pipelined.
//   Stall: when m_tready is low the output word holds; earlier stages keep
//   filling empty slots, so s_tready drops only once all six stages are full.
//   Reset: aresetn (synchronous, active low) empties the pipeline; s_tready
//   is low while reset is asserted.
// ----------------------------------------------------------------------------
`include "hsl_to_rgb_integer_defines.svh"

module hsl_to_rgb_integer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // hue_deg[8:0], sat_pct[15:9], light_pct[22:16], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata     // red[7:0], green[15:8], blue[23:16]
);
    import hslrgb_pkg::*;

    localparam int NSTG = 6;

    logic [NSTG:1] v_reg, rdy, v_feed;
    logic          in_fire, out_fire;

    // Stage 1: wrap hue, clamp percents
    logic [HUE_W-1:0]  hue_in, hue1_next, hue1_reg;
    logic [PCT_W-1:0]  sat_in, lit_in, sat1_next, lit1_next, sat1_reg, lit1_reg;

    // Stage 2: upper level and ramp weights
    logic [LEVEL_W:0]    up_dark, up_light_a, up_light_b;
    logic [LEVEL_W-1:0]  upper2_next, upper2_reg;
    logic [HUE_W-1:0]    pos_r, pos_b;
    logic [WEIGHT_W-1:0] w_r2_next, w_g2_next, w_b2_next;
    logic [WEIGHT_W-1:0] w_r2_reg, w_g2_reg, w_b2_reg;
    logic [PCT_W-1:0]    lit2_reg;

    // Stage 3: lower level and level difference
    logic [LEVEL_W:0]    lit_sum;
    logic [LEVEL_W-1:0]  lower3_next, diff3_next, lower3_reg, diff3_reg;
    logic [WEIGHT_W-1:0] w_r3_reg, w_g3_reg, w_b3_reg;

    hslrgb_stage_t       stage;
    logic [CHAN_W-1:0]   red, green, blue;

    // Weight of the upper level at a hue position, out of 60
    function automatic logic [WEIGHT_W-1:0] ramp_weight(input logic [HUE_W-1:0] pos);
        logic [WEIGHT_W-1:0] w;
        if (pos < HUE_W'(SEG_RISE_END)) begin
            w = WEIGHT_W'(pos);
        end else if (pos < HUE_W'(SEG_FLAT_END)) begin
            w = WEIGHT_W'(SEG_RISE_END);
        end else if (pos < HUE_W'(SEG_FALL_END)) begin
            w = WEIGHT_W'(HUE_W'(SEG_FALL_END) - pos);
        end else begin
            w = '0;
        end
        return w;
    endfunction

    // Ready runs back from the output; an empty stage always takes a word
    always_comb begin
        rdy[NSTG] = !v_reg[NSTG] || m_tready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign v_feed   = {v_reg[NSTG-1:1], s_tvalid};
    assign s_tready = rdy[1] && aresetn;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 1; k <= NSTG; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_feed[k];
                end
            end
        end
    end

    // Stage 1 logic
    assign hue_in    = s_tdata[8:0];
    assign sat_in    = s_tdata[15:9];
    assign lit_in    = s_tdata[22:16];
    assign hue1_next = (hue_in >= HUE_W'(HUE_WRAP)) ? hue_in - HUE_W'(HUE_WRAP) : hue_in;
    assign sat1_next = (sat_in > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : sat_in;
    assign lit1_next = (lit_in > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : lit_in;

    // Stage 2 logic
    assign up_dark    = (LEVEL_W+1)'(lit1_reg)
                      * ((LEVEL_W+1)'(sat1_reg) + (LEVEL_W+1)'(PCT_MAX));
    assign up_light_a = ((LEVEL_W+1)'(lit1_reg) + (LEVEL_W+1)'(sat1_reg))
                      * (LEVEL_W+1)'(PCT_MAX);
    assign up_light_b = (LEVEL_W+1)'(sat1_reg) * (LEVEL_W+1)'(lit1_reg);
    assign upper2_next = (lit1_reg < PCT_W'(PCT_HALF)) ? up_dark[LEVEL_W-1:0]
                       : LEVEL_W'(up_light_a - up_light_b);

    assign pos_r = (hue1_reg < HUE_W'(HUE_TWO_THRD)) ? hue1_reg + HUE_W'(HUE_THIRD)
                 : hue1_reg - HUE_W'(HUE_TWO_THRD);
    assign pos_b = (hue1_reg >= HUE_W'(HUE_THIRD)) ? hue1_reg - HUE_W'(HUE_THIRD)
                 : hue1_reg + HUE_W'(HUE_TWO_THRD);
    assign w_r2_next = ramp_weight(pos_r);
    assign w_g2_next = ramp_weight(hue1_reg);
    assign w_b2_next = ramp_weight(pos_b);

    // Stage 3 logic
    assign lit_sum     = (LEVEL_W+1)'(lit2_reg) * (LEVEL_W+1)'(LEVEL_SUM);
    assign lower3_next = LEVEL_W'(lit_sum - (LEVEL_W+1)'(upper2_reg));
    assign diff3_next  = upper2_reg - lower3_next;

    // Payload registers of stages 1 to 3
    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            hue1_reg <= hue1_next;
            sat1_reg <= sat1_next;
            lit1_reg <= lit1_next;
        end
        if (rdy[2]) begin
            upper2_reg <= upper2_next;
            lit2_reg   <= lit1_reg;
            w_r2_reg   <= w_r2_next;
            w_g2_reg   <= w_g2_next;
            w_b2_reg   <= w_b2_next;
        end
        if (rdy[3]) begin
            lower3_reg <= lower3_next;
            diff3_reg  <= diff3_next;
            w_r3_reg   <= w_r2_reg;
            w_g3_reg   <= w_g2_reg;
            w_b3_reg   <= w_b2_reg;
        end
    end

    // Stages 4 to 6 per channel
    always_comb begin
        stage.ld4  = rdy[4];
        stage.ld5  = rdy[5];
        stage.ld6  = rdy[6];
        stage.vld3 = v_reg[3];
        stage.vld4 = v_reg[4];
        stage.vld5 = v_reg[5];
    end

    hslrgb_chan u_chan_r (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stage   (stage),
        .lower   (lower3_reg),
        .diff    (diff3_reg),
        .weight  (w_r3_reg),
        .level   (red)
    );

    hslrgb_chan u_chan_g (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stage   (stage),
        .lower   (lower3_reg),
        .diff    (diff3_reg),
        .weight  (w_g3_reg),
        .level   (green)
    );

    hslrgb_chan u_chan_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stage   (stage),
        .lower   (lower3_reg),
        .diff    (diff3_reg),
        .weight  (w_b3_reg),
        .level   (blue)
    );

    assign m_tvalid = v_reg[NSTG];
    assign m_tdata  = {blue, green, red};

    `HSL_ASSERT_NEXT(a_occupancy, $past(aresetn), $countones(v_reg) == $past($countones(v_reg)) + int'($past(in_fire)) - int'($past(out_fire)), "pipeline word count drifted")
    `HSL_ASSERT_NEXT(a_stall_keeps, v_reg[NSTG] && !m_tready && v_reg[NSTG-1], v_reg[NSTG] && v_reg[NSTG-1], "word lost behind stalled output")

endmodule

// ===== dv/tb_hsl_to_rgb_integer.sv =====
// ----------------------------------------------------------------------------
// HSL to RGB converter testbench
// Streams pixels into the converter in random bursts while the result side
// stalls on its own pattern. A scoreboard predicts red, green and blue for
// every accepted pixel and compares each returned word, in order, field by
// field. Directed pixels cover the hue segment borders, wrap and clamp
// cases and grey; random pixels follow.
// ----------------------------------------------------------------------------
module tb_hsl_to_rgb_integer;
    import hslrgb_pkg::*;

    // Pixel and color layouts, last field in the lowest bits
    typedef struct packed {
        logic [PCT_W-1:0] light;
        logic [PCT_W-1:0] sat;
        logic [HUE_W-1:0] hue;
    } hsl_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

    typedef enum int {RDY_FULL, RDY_MOSTLY, RDY_SPARSE, RDY_PERIODIC} ready_mode_t;

    localparam int CHAN_MAX   = (1 << CHAN_W) - 1;
    localparam int N_RANDOM   = 400;
    localparam int DRAIN_MAX  = 20000;
    localparam int SETTLE_CYC = 10;

    // Scoreboard: predict each accepted pixel, match results in order
    class rgb_scoreboard;
        rgb_t rgb_pending[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        // Piecewise hue ramp, scaled by 60
        function automatic longint unsigned ramp_at(longint unsigned lo,
                                                    longint unsigned hi,
                                                    longint unsigned pos);
            if (pos < SEG_RISE_END)
                return lo * SEG_RISE_END + (hi - lo) * pos;
            if (pos < SEG_FLAT_END)
                return hi * SEG_RISE_END;
            if (pos < SEG_FALL_END)
                return lo * SEG_RISE_END + (hi - lo) * (SEG_FALL_END - pos);
            return lo * SEG_RISE_END;
        endfunction

        function automatic logic [CHAN_W-1:0] to_channel(longint unsigned ramp);
            longint unsigned scaled;
            scaled = (ramp * CHAN_MAX) / RAMP_MAX;
            return scaled[CHAN_W-1:0];
        endfunction

        function automatic rgb_t rgb_for(hsl_t px);
            longint unsigned h, s, l, upper, lower, pos_r, pos_b;
            rgb_t c;
            h = 64'(px.hue);
            s = 64'(px.sat);
            l = 64'(px.light);
            if (h >= HUE_WRAP) h = h % HUE_WRAP;
            if (s > PCT_MAX) s = PCT_MAX;
            if (l > PCT_MAX) l = PCT_MAX;
            if (s == 0) begin
                c.red   = CHAN_W'((l * CHAN_MAX) / PCT_MAX);
                c.green = c.red;
                c.blue  = c.red;
            end else begin
                if (l < PCT_HALF)
                    upper = l * (PCT_MAX + s);
                else
                    upper = (l + s) * PCT_MAX - s * l;
                lower = l * LEVEL_SUM - upper;
                pos_r = (h < HUE_TWO_THRD) ? h + HUE_THIRD : h - HUE_TWO_THRD;
                pos_b = (h >= HUE_THIRD) ? h - HUE_THIRD : h + HUE_TWO_THRD;
                c.red   = to_channel(ramp_at(lower, upper, pos_r));
                c.green = to_channel(ramp_at(lower, upper, h));
                c.blue  = to_channel(ramp_at(lower, upper, pos_b));
            end
            return c;
        endfunction

        function void note_pixel(logic [23:0] word);
            rgb_pending.push_back(rgb_for(hsl_t'(word[22:0])));
        endfunction

        function void check_rgb(logic [23:0] word);
            rgb_t got, want;
            got = rgb_t'(word);
            if (rgb_pending.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, word);
                errors++;
                return;
            end
            want = rgb_pending.pop_front();
            if (got.red !== want.red) begin
                $display("%0t: red mismatch, expected %0d, actual %0d",
                         $time, want.red, got.red);
                errors++;
            end
            if (got.green !== want.green) begin
                $display("%0t: green mismatch, expected %0d, actual %0d",
                         $time, want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue) begin
                $display("%0t: blue mismatch, expected %0d, actual %0d",
                         $time, want.blue, got.blue);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // hue_deg[8:0], sat_pct[15:9], light_pct[22:16], zero
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // red[7:0], green[15:8], blue[23:16]

    rgb_scoreboard sb = new();
    int            burst_left = 0;

    hsl_to_rgb_integer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // Note accepted pixels first, then check returned words
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_pixel(s_tdata);
        if (aresetn && m_tvalid && m_tready)
            sb.check_rgb(m_tdata);
    end

    // Stall the result side on a pattern that changes mode now and then
    initial begin
        ready_mode_t mode;
        int          left;
        int          phase;
        mode     = RDY_FULL;
        left     = 0;
        phase    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (left == 0) begin
                mode = ready_mode_t'($urandom_range(0, 3));
                left = $urandom_range(16, 96);
            end
            left--;
            phase++;
            case (mode)
                RDY_FULL:   m_tready <= 1'b1;
                RDY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:    m_tready <= ((phase % 7) < 3);
            endcase
        end
    end

    function automatic hsl_t pixel(int h, int s, int l);
        hsl_t px;
        px.hue   = HUE_W'(h);
        px.sat   = PCT_W'(s);
        px.light = PCT_W'(l);
        return px;
    endfunction

    // Send one pixel word; open a gap between bursts
    task automatic push_pixel(hsl_t px);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= {1'b0, 23'($urandom)};
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, px};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
    endtask

    // Random percent: mostly in range, some zero, some above the clamp
    function automatic int rand_pct(int low);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 0;
        if (pick == 1)
            return $urandom_range(PCT_MAX + 1, (1 << PCT_W) - 1);
        return $urandom_range(low, PCT_MAX);
    endfunction

    initial begin
        int guard;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: primaries, segment borders, wraps, clamps, grey
        push_pixel(pixel(0,   100, 50));
        push_pixel(pixel(120, 100, 50));
        push_pixel(pixel(240, 100, 50));
        push_pixel(pixel(59,  100, 50));
        push_pixel(pixel(60,  100, 50));
        push_pixel(pixel(179, 80,  40));
        push_pixel(pixel(180, 80,  40));
        push_pixel(pixel(239, 80,  40));
        push_pixel(pixel(300, 80,  40));
        push_pixel(pixel(359, 100, 50));
        push_pixel(pixel(360, 100, 50));
        push_pixel(pixel(450, 100, 100));
        push_pixel(pixel(511, 127, 127));
        push_pixel(pixel(0,   0,   0));
        push_pixel(pixel(0,   0,   100));
        push_pixel(pixel(200, 0,   127));
        push_pixel(pixel(77,  0,   33));
        push_pixel(pixel(100, 101, 49));
        push_pixel(pixel(30,  127, 50));
        push_pixel(pixel(10,  50,  49));
        push_pixel(pixel(10,  50,  50));
        push_pixel(pixel(45,  1,   1));
        push_pixel(pixel(90,  100, 0));
        push_pixel(pixel(15,  100, 101));

        // Random pixels
        for (int i = 0; i < N_RANDOM; i++)
            push_pixel(pixel($urandom_range(0, (1 << HUE_W) - 1), rand_pct(1), rand_pct(0)));
        s_tvalid <= 1'b0;

        // Drain the pipeline, then let it settle
        guard = 0;
        while (sb.rgb_pending.size() != 0 && guard < DRAIN_MAX) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYC) @(posedge aclk);
        if (sb.rgb_pending.size() != 0) begin
            $display("%0t: %0d results missing, expected %h, actual none",
                     $time, sb.rgb_pending.size(), sb.rgb_pending[0]);
            sb.errors++;
        end

        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
